### rtl/tcw_pkg.sv
package tcw_pkg;

    // Grid geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    // Field widths fixed by the interface
    localparam int ADDR_W  = 11;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int COUNT_W = 12;
    localparam int BYTE_W  = 8;
    localparam int REG_IDX_W = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 12'd4095;

    // Character codes
    localparam logic [BYTE_W-1:0] CHAR_BS    = 8'd8;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'd10;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CHAR_BLANK = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_NULL  = 8'h00;
    localparam logic [BYTE_W-1:0] ATTR_RESET = 8'h0C;

    // Operation codes
    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_CURSOR_ENABLE  = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_TEXT_ATTRIBUTE = 1'd1;

    typedef struct packed {
        logic [1:0]        mode;
        logic [BYTE_W-1:0] char_code;
        logic [ADDR_W-1:0] cell_index;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_char;
        logic [BYTE_W-1:0] read_attr;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic              cursor_update;
        logic [ADDR_W-1:0] cursor_position;
        logic              scrolled;
    } out_item_t;

    typedef struct packed {
        logic              cursor_enable;
        logic [BYTE_W-1:0] text_attribute;
    } cfg_t;

    typedef struct packed {
        logic              we_char;
        logic              we_attr;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] char_data;
        logic [BYTE_W-1:0] attr_data;
    } ram_wr_t;

    typedef struct packed {
        logic [BYTE_W-1:0] char_data;
        logic [BYTE_W-1:0] attr_data;
    } cell_t;

endpackage

### rtl/tcw_cell_ram.sv
module tcw_cell_ram (
    input  logic                               clk,
    input  tcw_pkg::ram_wr_t                   wr,
    input  logic [tcw_pkg::ADDR_W-1:0]         raddr,
    output tcw_pkg::cell_t                     rdata
);

    logic [tcw_pkg::BYTE_W-1:0] char_mem [tcw_pkg::CELLS];
    logic [tcw_pkg::BYTE_W-1:0] attr_mem [tcw_pkg::CELLS];
    tcw_pkg::cell_t             rdata_reg;

    // Write each byte lane under its own enable
    always_ff @(posedge clk)
    begin
        if (wr.we_char)
        begin
            char_mem[wr.addr] <= wr.char_data;
        end
        if (wr.we_attr)
        begin
            attr_mem[wr.addr] <= wr.attr_data;
        end
    end

    // Register the read port
    always_ff @(posedge clk)
    begin
        rdata_reg.char_data <= char_mem[raddr];
        rdata_reg.attr_data <= attr_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/tcw_engine.sv
module tcw_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  tcw_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_stall,
    input  tcw_pkg::in_item_t   in_data,
    output logic                res_valid,
    input  logic                res_take,
    output tcw_pkg::out_item_t  res_data
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_ATTR,
        S_SCROLL,
        S_SCROLL_TAIL,
        S_BLANK,
        S_CLEAR,
        S_DONE
    } state_t;

    state_t                         state_reg, state_next;
    tcw_pkg::in_item_t              item_reg, item_next;
    logic [tcw_pkg::COL_W-1:0]      col_reg, col_next;
    logic [tcw_pkg::ROW_W-1:0]      row_reg, row_next;
    logic [tcw_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [tcw_pkg::ADDR_W-1:0]     ptr_reg, ptr_next;
    logic [tcw_pkg::ADDR_W-1:0]     wptr_reg, wptr_next;
    logic                           pend_reg, pend_next;
    logic                           erase_reg, erase_next;
    logic                           attr_after_reg, attr_after_next;
    logic                           scr_reg, scr_next;
    logic [tcw_pkg::BYTE_W-1:0]     rd_char_reg, rd_char_next;
    logic [tcw_pkg::BYTE_W-1:0]     rd_attr_reg, rd_attr_next;

    tcw_pkg::ram_wr_t               wr;
    logic [tcw_pkg::ADDR_W-1:0]     raddr;
    tcw_pkg::cell_t                 rdata;
    logic [tcw_pkg::ADDR_W-1:0]     cur_addr;
    logic                           is_newline;
    logic                           is_update_mode;

    tcw_cell_ram u_ram (
        .clk   (clk),
        .wr    (wr),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Linear address of the cursor cell
    assign cur_addr = tcw_pkg::ADDR_W'(row_reg) * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS)
                    + tcw_pkg::ADDR_W'(col_reg);

    assign is_newline = (item_reg.char_code == tcw_pkg::CHAR_LF)
                     || (item_reg.char_code == tcw_pkg::CHAR_CR);

    assign is_update_mode = (item_reg.mode == tcw_pkg::MODE_PUT)
                         || (item_reg.mode == tcw_pkg::MODE_CLEAR);

    // Sequence the cell store accesses of one operation
    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        wptr_next       = wptr_reg;
        pend_next       = pend_reg;
        erase_next      = erase_reg;
        attr_after_next = attr_after_reg;
        scr_next        = scr_reg;
        rd_char_next    = rd_char_reg;
        rd_attr_next    = rd_attr_reg;

        wr.we_char   = 1'b0;
        wr.we_attr   = 1'b0;
        wr.addr      = cur_addr;
        wr.char_data = tcw_pkg::CHAR_NULL;
        wr.attr_data = cfg.text_attribute;
        raddr        = ptr_reg;

        case (state_reg)
            S_INIT:
            begin
                // Zero every cell after reset
                wr.we_char   = 1'b1;
                wr.we_attr   = 1'b1;
                wr.addr      = ptr_reg;
                wr.attr_data = tcw_pkg::CHAR_NULL;
                if (ptr_reg == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1))
                begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                scr_next        = 1'b0;
                erase_next      = 1'b0;
                attr_after_next = 1'b0;
                pend_next       = 1'b0;
                rd_char_next    = '0;
                rd_attr_next    = '0;
                ptr_next        = tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
                case (item_reg.mode)
                    tcw_pkg::MODE_PUT:
                    begin
                        if (is_newline)
                        begin
                            count_next = '0;
                            col_next   = '0;
                            if (row_reg == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1))
                            begin
                                scr_next   = 1'b1;
                                state_next = S_SCROLL;
                            end
                            else
                            begin
                                row_next   = row_reg + 1'b1;
                                state_next = S_DONE;
                            end
                        end
                        else if (item_reg.char_code == tcw_pkg::CHAR_BS)
                        begin
                            // Step back and erase unless nothing to erase or at origin
                            if ((count_reg != '0) && ((col_reg != '0) || (row_reg != '0)))
                            begin
                                erase_next = 1'b1;
                                count_next = count_reg - 1'b1;
                                if (col_reg == '0)
                                begin
                                    col_next = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
                                    row_next = row_reg - 1'b1;
                                end
                                else
                                begin
                                    col_next = col_reg - 1'b1;
                                end
                            end
                            state_next = S_ATTR;
                        end
                        else
                        begin
                            // Store the character under the cursor, then advance
                            wr.we_char   = 1'b1;
                            wr.char_data = item_reg.char_code;
                            if (count_reg != tcw_pkg::COUNT_MAX)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            if (col_reg == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1))
                            begin
                                col_next = '0;
                                if (row_reg == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1))
                                begin
                                    scr_next        = 1'b1;
                                    attr_after_next = 1'b1;
                                    state_next      = S_SCROLL;
                                end
                                else
                                begin
                                    row_next   = row_reg + 1'b1;
                                    state_next = S_ATTR;
                                end
                            end
                            else
                            begin
                                col_next   = col_reg + 1'b1;
                                state_next = S_ATTR;
                            end
                        end
                    end

                    tcw_pkg::MODE_READ:
                    begin
                        raddr = item_reg.cell_index;
                        if (item_reg.cell_index < tcw_pkg::ADDR_W'(tcw_pkg::CELLS))
                        begin
                            state_next = S_READ;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end

                    tcw_pkg::MODE_CLEAR:
                    begin
                        ptr_next   = '0;
                        state_next = S_CLEAR;
                    end

                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_READ:
            begin
                rd_char_next = rdata.char_data;
                rd_attr_next = rdata.attr_data;
                state_next   = S_DONE;
            end

            S_ATTR:
            begin
                // Attribute at the new cursor cell, with the erase folded in
                wr.we_attr = 1'b1;
                wr.we_char = erase_reg;
                state_next = S_DONE;
            end

            S_SCROLL:
            begin
                // Read one row ahead, write the cell read last cycle
                wr.we_char   = pend_reg;
                wr.we_attr   = pend_reg;
                wr.addr      = wptr_reg;
                wr.char_data = rdata.char_data;
                wr.attr_data = rdata.attr_data;
                pend_next    = 1'b1;
                wptr_next    = ptr_reg - tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
                if (ptr_reg == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1))
                begin
                    state_next = S_SCROLL_TAIL;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            S_SCROLL_TAIL:
            begin
                wr.we_char   = 1'b1;
                wr.we_attr   = 1'b1;
                wr.addr      = wptr_reg;
                wr.char_data = rdata.char_data;
                wr.attr_data = rdata.attr_data;
                pend_next    = 1'b0;
                ptr_next     = tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
                state_next   = S_BLANK;
            end

            S_BLANK:
            begin
                // Blank the bottom row
                wr.we_char = 1'b1;
                wr.we_attr = 1'b1;
                wr.addr    = ptr_reg;
                if (ptr_reg == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1))
                begin
                    state_next = attr_after_reg ? S_ATTR : S_DONE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            S_CLEAR:
            begin
                wr.we_char   = 1'b1;
                wr.we_attr   = 1'b1;
                wr.addr      = ptr_reg;
                wr.char_data = tcw_pkg::CHAR_BLANK;
                if (ptr_reg == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1))
                begin
                    col_next   = '0;
                    row_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and operation registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            col_reg        <= '0;
            row_reg        <= '0;
            count_reg      <= '0;
            ptr_reg        <= '0;
            pend_reg       <= 1'b0;
            erase_reg      <= 1'b0;
            attr_after_reg <= 1'b0;
            scr_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            count_reg      <= count_next;
            ptr_reg        <= ptr_next;
            pend_reg       <= pend_next;
            erase_reg      <= erase_next;
            attr_after_reg <= attr_after_next;
            scr_reg        <= scr_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        wptr_reg    <= wptr_next;
        rd_char_reg <= rd_char_next;
        rd_attr_reg <= rd_attr_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res_data.read_char       = rd_char_reg;
        res_data.read_attr       = rd_attr_reg;
        res_data.cursor_col      = col_reg;
        res_data.cursor_row      = row_reg;
        res_data.cursor_update   = is_update_mode & cfg.cursor_enable;
        res_data.cursor_position = cur_addr;
        res_data.scrolled        = scr_reg;
    end

endmodule

### rtl/text_console_writer.sv
// Text console writer: a 25 x 80 grid of character and attribute cells with a
// cursor. Each input transfer carries one operation (put character, read cell or
// clear screen) and yields exactly one output transfer with the cursor after the
// operation. After reset the block zeroes the cell store, one cell per cycle, and
// holds in_stall high meanwhile; configuration writes are taken throughout.
// Operations run one at a time through a single-write, single-read cell memory.
// A line break that does not scroll or an unused mode goes straight to the result;
// a character writes the cell and then the attribute at the new cursor cell, a
// backspace writes that attribute with the erase folded in, a read first fetches
// the cell, and a clear writes every cell, one cell per cycle. A put that leaves
// the bottom row scrolls the grid, one cell moved per cycle, then blanks the bottom
// row, and for a character then writes the attribute. The engine returns to idle
// when its result is taken and only then takes the next input transfer. The result
// waits in an output register, so the next operation may be taken while it is stalled.
module text_console_writer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  tcw_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output tcw_pkg::out_item_t                out_data,
    input  logic                              cfg_we,
    input  logic [tcw_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [tcw_pkg::BYTE_W-1:0]        cfg_data
);

    tcw_pkg::cfg_t      cfg_reg;
    logic               res_valid;
    logic               res_take;
    tcw_pkg::out_item_t res_data;
    logic               out_valid_reg;
    tcw_pkg::out_item_t out_data_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cursor_enable  <= 1'b0;
            cfg_reg.text_attribute <= tcw_pkg::ATTR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tcw_pkg::REG_CURSOR_ENABLE:
                begin
                    cfg_reg.cursor_enable <= cfg_data[0];
                end
                tcw_pkg::REG_TEXT_ATTRIBUTE:
                begin
                    cfg_reg.text_attribute <= cfg_data;
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    tcw_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res_data  (res_data)
    );

    // Take a result when the output register is empty or being drained
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### tb/tb_text_console_writer.sv
`timescale 1ns / 100ps

module tb_text_console_writer;

    // The unused operation code has no name in the package
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int TIMEOUT_NS  = 100_000_000;
    localparam int WRAP_RUN    = 90;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_kind_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    tcw_pkg::in_item_t             in_data = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    tcw_pkg::out_item_t            out_data;
    logic                          cfg_we = 1'b0;
    logic [tcw_pkg::REG_IDX_W-1:0] cfg_index = '0;
    logic [tcw_pkg::BYTE_W-1:0]    cfg_data = '0;

    text_console_writer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the console: cells, cursor, editable count and registers
    logic [tcw_pkg::BYTE_W-1:0] grid_char [tcw_pkg::CELLS];
    logic [tcw_pkg::BYTE_W-1:0] grid_attr [tcw_pkg::CELLS];
    int                         cur_col = 0;
    int                         cur_row = 0;
    int                         edit_count = 0;
    logic                       cfg_cursor_en = 1'b0;
    logic [tcw_pkg::BYTE_W-1:0] cfg_attr = tcw_pkg::ATTR_RESET;

    tcw_pkg::in_item_t  queued_ops[$];
    tcw_pkg::out_item_t expected_reports[$];
    int        ops_queued = 0;
    int        ops_taken = 0;
    int        reports_seen = 0;
    int        mismatches = 0;
    int        read_count = 0;
    int        scroll_count = 0;
    int        clear_count = 0;
    bit        in_fire = 1'b0;

    int          burst_left = 1;
    int          gap_left = 0;
    int          hold_left = 0;
    int          hold_idx = 0;
    int          hold_marks [2] = '{60, 300};
    int          pattern_left = 0;
    stall_kind_t stall_kind = STALL_NONE;

    always #5 clk = ~clk;

    // Move to the start of the next row, scrolling the grid at the bottom
    function automatic bit advance_row();
        int i;
        cur_col = 0;
        cur_row++;
        if (cur_row < tcw_pkg::ROWS)
            return 1'b0;
        for (i = 0; i < tcw_pkg::CELLS - tcw_pkg::COLUMNS; i++)
        begin
            grid_char[i] = grid_char[i + tcw_pkg::COLUMNS];
            grid_attr[i] = grid_attr[i + tcw_pkg::COLUMNS];
        end
        for (i = tcw_pkg::CELLS - tcw_pkg::COLUMNS; i < tcw_pkg::CELLS; i++)
        begin
            grid_char[i] = tcw_pkg::CHAR_NULL;
            grid_attr[i] = cfg_attr;
        end
        cur_row = tcw_pkg::ROWS - 1;
        scroll_count++;
        return 1'b1;
    endfunction

    // Apply one character: line break, backspace or printable
    function automatic bit apply_put(logic [tcw_pkg::BYTE_W-1:0] code);
        bit scr;
        scr = 1'b0;
        if (code == tcw_pkg::CHAR_LF || code == tcw_pkg::CHAR_CR)
        begin
            edit_count = 0;
            return advance_row();
        end
        if (code == tcw_pkg::CHAR_BS)
        begin
            // erase only with typed characters left and not at the top-left corner
            if (edit_count != 0 && (cur_col != 0 || cur_row != 0))
            begin
                if (cur_col == 0)
                begin
                    cur_col = tcw_pkg::COLUMNS - 1;
                    cur_row--;
                end
                else
                    cur_col--;
                edit_count--;
                grid_char[cur_row * tcw_pkg::COLUMNS + cur_col] = tcw_pkg::CHAR_NULL;
            end
        end
        else
        begin
            grid_char[cur_row * tcw_pkg::COLUMNS + cur_col] = code;
            cur_col++;
            if (edit_count < tcw_pkg::COUNT_MAX)
                edit_count++;
            if (cur_col >= tcw_pkg::COLUMNS)
                scr = advance_row();
        end
        grid_attr[cur_row * tcw_pkg::COLUMNS + cur_col] = cfg_attr;
        return scr;
    endfunction

    // Work out the result of one operation and advance the mirror
    function automatic tcw_pkg::out_item_t console_step(tcw_pkg::in_item_t op);
        tcw_pkg::out_item_t res;
        int                 i;
        res = '0;
        case (op.mode)
            tcw_pkg::MODE_PUT:
            begin
                res.scrolled      = apply_put(op.char_code);
                res.cursor_update = cfg_cursor_en;
            end
            tcw_pkg::MODE_READ:
            begin
                read_count++;
                if (op.cell_index < tcw_pkg::CELLS)
                begin
                    res.read_char = grid_char[op.cell_index];
                    res.read_attr = grid_attr[op.cell_index];
                end
            end
            tcw_pkg::MODE_CLEAR:
            begin
                for (i = 0; i < tcw_pkg::CELLS; i++)
                begin
                    grid_char[i] = tcw_pkg::CHAR_BLANK;
                    grid_attr[i] = cfg_attr;
                end
                cur_col = 0;
                cur_row = 0;
                res.cursor_update = cfg_cursor_en;
                clear_count++;
            end
            default: ;
        endcase
        res.cursor_col      = tcw_pkg::COL_W'(cur_col);
        res.cursor_row      = tcw_pkg::ROW_W'(cur_row);
        res.cursor_position = tcw_pkg::ADDR_W'(cur_row * tcw_pkg::COLUMNS + cur_col);
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("mismatch: %s", msg);
    endtask

    task automatic check_field(string name, logic [tcw_pkg::ADDR_W-1:0] got,
                               logic [tcw_pkg::ADDR_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                      reports_seen, name, got, want));
    endtask

    task automatic compare_report(tcw_pkg::out_item_t got, tcw_pkg::out_item_t want);
        check_field("read_char", tcw_pkg::ADDR_W'(got.read_char),
                    tcw_pkg::ADDR_W'(want.read_char));
        check_field("read_attr", tcw_pkg::ADDR_W'(got.read_attr),
                    tcw_pkg::ADDR_W'(want.read_attr));
        check_field("cursor_col", tcw_pkg::ADDR_W'(got.cursor_col),
                    tcw_pkg::ADDR_W'(want.cursor_col));
        check_field("cursor_row", tcw_pkg::ADDR_W'(got.cursor_row),
                    tcw_pkg::ADDR_W'(want.cursor_row));
        check_field("cursor_update", tcw_pkg::ADDR_W'(got.cursor_update),
                    tcw_pkg::ADDR_W'(want.cursor_update));
        check_field("cursor_position", got.cursor_position, want.cursor_position);
        check_field("scrolled", tcw_pkg::ADDR_W'(got.scrolled),
                    tcw_pkg::ADDR_W'(want.scrolled));
    endtask

    // Check each result transfer, then record the input transfer of this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                reports_seen++;
                if (expected_reports.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              reports_seen));
                else
                    compare_report(out_data, expected_reports.pop_front());
            end
            in_fire = in_valid && !in_stall;
            if (in_fire)
            begin
                expected_reports.push_back(console_step(in_data));
                ops_taken++;
            end
        end
    end

    // Offer queued operations in bursts; hold a stalled transfer unchanged
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (queued_ops.size() != 0)
            begin
                in_valid <= 1'b1;
                in_data  <= queued_ops.pop_front();
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Stall results on a changing pattern, with long hold-offs at set points
    always @(negedge clk)
    begin
        if (hold_idx < 2 && ops_taken >= hold_marks[hold_idx])
        begin
            hold_idx++;
            hold_left = HOLD_CYCLES;
        end
        if (pattern_left == 0)
        begin
            stall_kind   = stall_kind_t'($urandom_range(0, 2));
            pattern_left = $urandom_range(20, 200);
        end
        pattern_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            case (stall_kind)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                default:     out_stall <= ($urandom_range(0, 3) != 0);
            endcase
    end

    task automatic write_reg(logic [tcw_pkg::REG_IDX_W-1:0] idx,
                             logic [tcw_pkg::BYTE_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == tcw_pkg::REG_CURSOR_ENABLE)
            cfg_cursor_en = value[0];
        else if (idx == tcw_pkg::REG_TEXT_ATTRIBUTE)
            cfg_attr = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(bit enable, logic [tcw_pkg::BYTE_W-1:0] attr);
        write_reg(tcw_pkg::REG_CURSOR_ENABLE, {{(tcw_pkg::BYTE_W - 1){1'b0}}, enable});
        write_reg(tcw_pkg::REG_TEXT_ATTRIBUTE, attr);
    endtask

    // Wait until every queued operation has gone in and its result come back
    task automatic drain();
        while (ops_taken != ops_queued || expected_reports.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic queue_op(logic [1:0] mode, logic [tcw_pkg::BYTE_W-1:0] code,
                            logic [tcw_pkg::ADDR_W-1:0] idx);
        tcw_pkg::in_item_t op;
        op.mode       = mode;
        op.char_code  = code;
        op.cell_index = idx;
        queued_ops.push_back(op);
        ops_queued++;
    endtask

    function automatic logic [tcw_pkg::BYTE_W-1:0] any_code();
        return tcw_pkg::BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [tcw_pkg::BYTE_W-1:0] printable_code();
        logic [tcw_pkg::BYTE_W-1:0] c;
        c = any_code();
        while (c == tcw_pkg::CHAR_BS || c == tcw_pkg::CHAR_LF || c == tcw_pkg::CHAR_CR)
            c = any_code();
        return c;
    endfunction

    // Cell to read: favour the rows where text lands, sometimes off the grid
    function automatic logic [tcw_pkg::ADDR_W-1:0] read_index();
        case ($urandom_range(0, 7))
            0:
                return tcw_pkg::ADDR_W'($urandom_range(tcw_pkg::CELLS, 2047));
            1, 2, 3:
                return tcw_pkg::ADDR_W'($urandom_range(tcw_pkg::CELLS - 3 * tcw_pkg::COLUMNS,
                                                       tcw_pkg::CELLS - 1));
            4, 5:
                return tcw_pkg::ADDR_W'($urandom_range(0, 3 * tcw_pkg::COLUMNS - 1));
            default:
                return tcw_pkg::ADDR_W'($urandom_range(0, tcw_pkg::CELLS - 1));
        endcase
    endfunction

    function automatic logic [tcw_pkg::ADDR_W-1:0] any_index();
        return tcw_pkg::ADDR_W'($urandom_range(0, 2047));
    endfunction

    // A line of text with the odd backspace and read, closed by a line break
    task automatic add_text_line();
        int len;
        int k;
        len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom_range(9, 100);
        for (k = 0; k < len; k++)
            case ($urandom_range(0, 19))
                0:       queue_op(tcw_pkg::MODE_PUT, tcw_pkg::CHAR_BS, any_index());
                1:       queue_op(tcw_pkg::MODE_READ, any_code(), read_index());
                default: queue_op(tcw_pkg::MODE_PUT, printable_code(), any_index());
            endcase
        queue_op(tcw_pkg::MODE_PUT, $urandom_range(0, 1) ? tcw_pkg::CHAR_LF : tcw_pkg::CHAR_CR,
                 any_index());
    endtask

    task automatic random_ops(int n);
        int target;
        int pick;
        int k;
        target = ops_queued + n;
        while (ops_queued < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                add_text_line();
            else if (pick < 60)
                repeat (($urandom_range(0, 3) == 0) ? $urandom_range(13, 90)
                                                    : $urandom_range(1, 12))
                    queue_op(tcw_pkg::MODE_PUT, tcw_pkg::CHAR_BS, any_index());
            else if (pick < 75)
                repeat ($urandom_range(1, 6))
                    queue_op(tcw_pkg::MODE_READ, any_code(), read_index());
            else if (pick < 82)
                repeat ($urandom_range(1, 4))
                    queue_op(tcw_pkg::MODE_PUT, tcw_pkg::CHAR_LF, any_index());
            else if (pick < 85)
                queue_op(tcw_pkg::MODE_CLEAR, any_code(), any_index());
            else
                for (k = $urandom_range(1, 4); k > 0; k--)
                    queue_op(2'($urandom_range(0, 3)), any_code(), any_index());
        end
    endtask

    initial
    begin
        int i;
        for (i = 0; i < tcw_pkg::CELLS; i++)
        begin
            grid_char[i] = tcw_pkg::CHAR_NULL;
            grid_attr[i] = tcw_pkg::CHAR_NULL;
        end
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: grid edges, every operation, backspace corner cases
        configure(1'b1, 8'hFF);
        queue_op(tcw_pkg::MODE_READ, 8'h00, 11'd0);
        queue_op(tcw_pkg::MODE_READ, 8'hFF, tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1));
        queue_op(tcw_pkg::MODE_READ, 8'h00, tcw_pkg::ADDR_W'(tcw_pkg::CELLS));
        queue_op(tcw_pkg::MODE_READ, 8'h00, 11'd2047);
        queue_op(tcw_pkg::MODE_PUT, tcw_pkg::CHAR_BS, 11'd0);
        queue_op(tcw_pkg::MODE_PUT, 8'h41, 11'd2047);
        queue_op(tcw_pkg::MODE_PUT, 8'hFF, 11'd0);
        queue_op(tcw_pkg::MODE_PUT, 8'h00, 11'd0);
        queue_op(tcw_pkg::MODE_PUT, tcw_pkg::CHAR_BS, 11'd0);
        queue_op(tcw_pkg::MODE_READ, 8'h00, 11'd2);
        queue_op(tcw_pkg::MODE_PUT, tcw_pkg::CHAR_LF, 11'd0);
        queue_op(tcw_pkg::MODE_PUT, 8'h7F, 11'd0);
        queue_op(tcw_pkg::MODE_PUT, tcw_pkg::CHAR_BS, 11'd0);
        queue_op(tcw_pkg::MODE_PUT, tcw_pkg::CHAR_BS, 11'd0);
        queue_op(tcw_pkg::MODE_PUT, tcw_pkg::CHAR_CR, 11'd0);
        queue_op(tcw_pkg::MODE_PUT, 8'h78, 11'd0);
        queue_op(tcw_pkg::MODE_PUT, 8'h79, 11'd0);
        queue_op(tcw_pkg::MODE_CLEAR, 8'h00, 11'd0);
        queue_op(tcw_pkg::MODE_PUT, tcw_pkg::CHAR_BS, 11'd0);
        queue_op(tcw_pkg::MODE_PUT, 8'h7A, 11'd0);
        queue_op(tcw_pkg::MODE_PUT, tcw_pkg::CHAR_BS, 11'd0);
        queue_op(tcw_pkg::MODE_PUT, tcw_pkg::CHAR_BS, 11'd0);
        queue_op(MODE_SPARE, 8'hFF, 11'd2047);
        queue_op(tcw_pkg::MODE_READ, 8'h00, 11'd0);
        queue_op(tcw_pkg::MODE_READ, 8'h00, 11'd81);
        drain();

        configure(1'b0, 8'h00);
        random_ops(90);
        drain();

        configure(1'b1, any_code());
        random_ops(90);
        drain();

        // Type across a row boundary, then erase back over it
        configure(1'b1, any_code());
        queue_op(tcw_pkg::MODE_CLEAR, 8'h00, 11'd0);
        for (i = 0; i < WRAP_RUN; i++)
            queue_op(tcw_pkg::MODE_PUT, printable_code(), any_index());
        repeat (30) queue_op(tcw_pkg::MODE_PUT, tcw_pkg::CHAR_BS, any_index());
        repeat (6) queue_op(tcw_pkg::MODE_READ, 8'h00, read_index());
        drain();

        configure(1'b0, 8'hFF);
        random_ops(90);
        drain();

        configure(1'b1, tcw_pkg::ATTR_RESET);
        random_ops(90);
        drain();

        $display("covered %0d operations: %0d reads, %0d clears, %0d scrolls",
                 ops_taken, read_count, clear_count, scroll_count);
        $display("checked %0d results, %0d mismatches", reports_seen, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Give up on a hung run
    initial
    begin
        #TIMEOUT_NS;
        $display("timeout with %0d results outstanding", expected_reports.size());
        $display("FAIL");
        $finish;
    end

endmodule
